>>> src/temp_sensor_sample_fifo_top_macros.svh
// assertion macros for the sample fifo modules, used by tsf_ctrl
// depends on nothing; included by files that carry concurrent checks
`ifndef TEMP_SENSOR_SAMPLE_FIFO_TOP_MACROS_SVH
`define TEMP_SENSOR_SAMPLE_FIFO_TOP_MACROS_SVH

// same-cycle implication
`define TSF_ASSERT_IMPL(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("sample fifo check failed");

// next-cycle implication
`define TSF_ASSERT_NEXT(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("sample fifo check failed");

`endif

>>> src/tsf_pkg.sv
// constants, codes and control structs of the temperature sample fifo
// no dependencies; used by every module of the block but tsf_ram
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);

  localparam int TEMP_W     = 21;
  localparam int FLAG_W     = 2;
  localparam int TIME_W     = 64;
  localparam int RAND_W     = 32;
  localparam int CNT_W      = 32;
  localparam int PERIOD_W   = 16;
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam int ENTRY_W = TEMP_W + FLAG_W + TIME_W;
  localparam int E_NEW   = TEMP_W;
  localparam int E_ALERT = TEMP_W + 1;

  localparam int IN_DATA_W  = (((TIME_W + RAND_W) + 7) / 8) * 8;
  localparam int OUT_BITS   = TEMP_W + FLAG_W + TIME_W + 2 + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int RAMP_START   = 20000;
  localparam int RAMP_STEP    = 500;
  localparam int RAMP_MAX     = 60000;
  localparam int NORMAL_DELTA = 2000;
  localparam int NOISY_DELTA  = 10000;

  localparam int T_MIN = -(2 ** (TEMP_W - 1));
  localparam int T_MAX = (2 ** (TEMP_W - 1)) - 1;

  localparam int MAX_DELTA = (NOISY_DELTA > NORMAL_DELTA) ? NOISY_DELTA : NORMAL_DELTA;
  localparam int MIN_DELTA = (NOISY_DELTA < NORMAL_DELTA) ? NOISY_DELTA : NORMAL_DELTA;
  localparam int DIV_W     = $clog2(2 * MAX_DELTA);
  localparam int RECIP_W   = RAND_W + 1 - $clog2(2 * MIN_DELTA);
  localparam int PROD_W    = RAND_W + RECIP_W;
  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SUM_W     = (((DIV_W + 1) > TEMP_W) ? (DIV_W + 1) : TEMP_W) + 2;

  // floor(2^32 / modulus), the quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] NORMAL_RECIP =
    RECIP_W'((64'd1 << RAND_W) / (2 * NORMAL_DELTA));
  localparam logic [RECIP_W-1:0] NOISY_RECIP =
    RECIP_W'((64'd1 << RAND_W) / (2 * NOISY_DELTA));

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MEAN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISY_MEAN = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_NOISY  = 2'd1,
    MODE_RAMP   = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    RES_TICK   = 3'd0,
    RES_SAMPLE = 3'd1,
    RES_READ   = 3'd2,
    RES_EMPTY  = 3'd3,
    RES_STATUS = 3'd4
  } code_t;

  typedef struct packed {
    logic latch;
    logic tick_eval;
    logic div_init;
    logic div_step;
    logic calc;
    logic push;
    logic read_empty;
    logic pop;
    logic lookup;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic              mode_ramp;
    logic              empty;
    logic              full;
    logic              more;
    logic              div_last;
  } status_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> src/tsf_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/tsf_datapath.sv
// datapath: config registers, tick divider, remainder unit, ring and counters
// depends on tsf_pkg and tsf_ram
`timescale 1ns / 1ps
`default_nettype none

module tsf_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr,
  input  wire logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [tsf_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [tsf_pkg::TIME_W-1:0]        in_stamp_ns,
  input  wire logic [tsf_pkg::RAND_W-1:0]        in_random_word,
  input  wire tsf_pkg::cmd_t                     cmd,
  output tsf_pkg::status_t                       st,
  output logic      [tsf_pkg::CODE_W-1:0]        result_code,
  output logic signed [tsf_pkg::TEMP_W-1:0]      sample_temp_mc,
  output logic      [tsf_pkg::FLAG_W-1:0]        sample_flags,
  output logic      [tsf_pkg::TIME_W-1:0]        sample_time_ns,
  output logic                                   data_ready,
  output logic                                   alert_pending,
  output logic      [tsf_pkg::CNT_W-1:0]         update_total,
  output logic      [tsf_pkg::CNT_W-1:0]         alert_total
);

  localparam int THRESH_RESET = 45000;
  localparam int PERIOD_RESET = 1000;
  localparam int MEAN_RESET   = 40000;

  // config
  logic [tsf_pkg::MODE_W-1:0]          mode;
  logic signed [tsf_pkg::TEMP_W-1:0]   thresh;
  logic [tsf_pkg::PERIOD_W-1:0]        period;
  logic signed [tsf_pkg::TEMP_W-1:0]   norm_mean;
  logic signed [tsf_pkg::TEMP_W-1:0]   noisy_mean;

  // latched item
  logic [tsf_pkg::KIND_W-1:0]          item_kind;
  logic [tsf_pkg::TIME_W-1:0]          item_time;
  logic [tsf_pkg::RAND_W-1:0]          item_rand;

  // state
  logic [tsf_pkg::PERIOD_W-1:0]        tick_count;
  logic [tsf_pkg::IDX_W-1:0]           wr_idx;
  logic [tsf_pkg::IDX_W-1:0]           rd_idx;
  logic signed [tsf_pkg::TEMP_W-1:0]   ramp;
  logic [tsf_pkg::CNT_W-1:0]           upd_cnt;
  logic [tsf_pkg::CNT_W-1:0]           alr_cnt;
  logic                                oldest_alert;

  // remainder unit
  logic [tsf_pkg::DIV_W-1:0]           rem;
  logic [tsf_pkg::PROD_W-1:0]          prod;
  logic [tsf_pkg::DIV_W:0]             rem_est;
  logic [tsf_pkg::DIV_CNT_W-1:0]       dcnt;
  logic [tsf_pkg::RECIP_W-1:0]         quot;
  logic [tsf_pkg::RAND_W-1:0]          quot_mul;
  logic [tsf_pkg::DIV_W:0]             rem_diff;
  logic [tsf_pkg::DIV_W:0]             rem_next;
  logic [tsf_pkg::DIV_W:0]             modulus;
  logic [tsf_pkg::RECIP_W-1:0]         recip;

  // sample arithmetic
  logic signed [tsf_pkg::TEMP_W-1:0]   temp;
  logic signed [tsf_pkg::TEMP_W-1:0]   mean_sel;
  logic signed [tsf_pkg::SUM_W-1:0]    delta_x;
  logic signed [tsf_pkg::SUM_W-1:0]    rand_sum;
  logic signed [tsf_pkg::SUM_W-1:0]    ramp_inc;
  logic signed [tsf_pkg::SUM_W-1:0]    ramp_next;
  logic signed [tsf_pkg::SUM_W-1:0]    calc_sum;
  logic                                alert_flag;
  logic [tsf_pkg::PERIOD_W:0]          tick_inc;

  // working result
  tsf_pkg::code_t                      res_code;
  logic signed [tsf_pkg::TEMP_W-1:0]   res_temp;
  logic [tsf_pkg::FLAG_W-1:0]          res_flags;
  logic [tsf_pkg::TIME_W-1:0]          res_time;

  // ring
  logic                                ram_we;
  logic [tsf_pkg::ENTRY_W-1:0]         ram_wdata;
  logic [tsf_pkg::ENTRY_W-1:0]         ram_rdata;

  function automatic logic signed [tsf_pkg::TEMP_W-1:0] sat_temp(
    input logic signed [tsf_pkg::SUM_W-1:0] v
  );
    if (v < tsf_pkg::SUM_W'(tsf_pkg::T_MIN)) begin
      return tsf_pkg::TEMP_W'(tsf_pkg::T_MIN);
    end else if (v > tsf_pkg::SUM_W'(tsf_pkg::T_MAX)) begin
      return tsf_pkg::TEMP_W'(tsf_pkg::T_MAX);
    end
    return v[tsf_pkg::TEMP_W-1:0];
  endfunction

  always_comb begin
    if (mode == tsf_pkg::MODE_NOISY) begin
      modulus  = (tsf_pkg::DIV_W + 1)'(2 * tsf_pkg::NOISY_DELTA);
      recip    = tsf_pkg::NOISY_RECIP;
      delta_x  = tsf_pkg::SUM_W'(tsf_pkg::NOISY_DELTA);
      mean_sel = noisy_mean;
    end else begin
      modulus  = (tsf_pkg::DIV_W + 1)'(2 * tsf_pkg::NORMAL_DELTA);
      recip    = tsf_pkg::NORMAL_RECIP;
      delta_x  = tsf_pkg::SUM_W'(tsf_pkg::NORMAL_DELTA);
      mean_sel = norm_mean;
    end
  end

  // quotient estimate from the reciprocal, then one correcting subtract
  assign quot     = prod[tsf_pkg::PROD_W-1:tsf_pkg::RAND_W];
  assign quot_mul = tsf_pkg::RAND_W'(quot) * tsf_pkg::RAND_W'(modulus);
  assign rem_diff = (tsf_pkg::DIV_W + 1)'(item_rand - quot_mul);
  assign rem_next = (rem_est >= modulus) ? rem_est - modulus : rem_est;

  assign rand_sum  = tsf_pkg::SUM_W'(mean_sel) + $signed(tsf_pkg::SUM_W'(rem)) - delta_x;
  assign ramp_inc  = tsf_pkg::SUM_W'(ramp) + tsf_pkg::SUM_W'(tsf_pkg::RAMP_STEP);
  assign ramp_next = (ramp_inc > tsf_pkg::SUM_W'(tsf_pkg::RAMP_MAX)) ?
                     tsf_pkg::SUM_W'(tsf_pkg::RAMP_START) : ramp_inc;
  assign calc_sum  = (mode == tsf_pkg::MODE_RAMP) ? ramp_next : rand_sum;

  assign alert_flag = temp > thresh;
  assign tick_inc   = {1'b0, tick_count} + 1'b1;

  assign st.kind      = item_kind;
  assign st.hit       = tick_inc >= {1'b0, period};
  assign st.mode_ramp = mode == tsf_pkg::MODE_RAMP;
  assign st.empty     = wr_idx == rd_idx;
  assign st.full      = tsf_pkg::next_idx(wr_idx) == rd_idx;
  assign st.more      = tsf_pkg::next_idx(rd_idx) != wr_idx;
  assign st.div_last  = dcnt == tsf_pkg::DIV_CNT_W'(tsf_pkg::DIV_STEPS - 1);

  assign ram_we    = cmd.push;
  assign ram_wdata = {item_time, alert_flag, 1'b1, temp};

  tsf_ram #(
    .WIDTH (tsf_pkg::ENTRY_W),
    .DEPTH (tsf_pkg::DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= tsf_pkg::MODE_NORMAL;
      thresh     <= tsf_pkg::TEMP_W'(THRESH_RESET);
      period     <= tsf_pkg::PERIOD_W'(PERIOD_RESET);
      norm_mean  <= tsf_pkg::TEMP_W'(MEAN_RESET);
      noisy_mean <= tsf_pkg::TEMP_W'(MEAN_RESET);
    end else if (cfg_wr) begin
      case (cfg_index)
        tsf_pkg::CFG_MODE:       mode       <= cfg_data[tsf_pkg::MODE_W-1:0];
        tsf_pkg::CFG_THRESHOLD:  thresh     <= cfg_data[tsf_pkg::TEMP_W-1:0];
        tsf_pkg::CFG_PERIOD:     period     <= cfg_data[tsf_pkg::PERIOD_W-1:0];
        tsf_pkg::CFG_NORM_MEAN:  norm_mean  <= cfg_data[tsf_pkg::TEMP_W-1:0];
        tsf_pkg::CFG_NOISY_MEAN: noisy_mean <= cfg_data[tsf_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // control state of the ring and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      wr_idx       <= '0;
      rd_idx       <= '0;
      ramp         <= tsf_pkg::TEMP_W'(tsf_pkg::RAMP_START);
      upd_cnt      <= '0;
      alr_cnt      <= '0;
      oldest_alert <= 1'b0;
    end else begin
      if (cmd.tick_eval) begin
        tick_count <= st.hit ? '0 : tick_inc[tsf_pkg::PERIOD_W-1:0];
      end
      if (cmd.calc && st.mode_ramp) begin
        ramp <= sat_temp(ramp_next);
      end
      if (cmd.push) begin
        wr_idx  <= tsf_pkg::next_idx(wr_idx);
        upd_cnt <= upd_cnt + 1'b1;
        if (alert_flag) begin
          alr_cnt <= alr_cnt + 1'b1;
        end
        if (st.full) begin
          rd_idx <= tsf_pkg::next_idx(rd_idx);
        end
        if (st.empty) begin
          oldest_alert <= alert_flag;
        end
      end
      if (cmd.pop) begin
        rd_idx <= tsf_pkg::next_idx(rd_idx);
        if (!st.more) begin
          oldest_alert <= 1'b0;
        end
      end
      if (cmd.lookup) begin
        oldest_alert <= ram_rdata[tsf_pkg::E_ALERT];
      end
    end
  end

  // item, remainder unit, sample and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_kind <= in_kind;
      item_time <= in_stamp_ns;
      item_rand <= in_random_word;
      res_code  <= (in_kind == tsf_pkg::KIND_STATUS) ? tsf_pkg::RES_STATUS : tsf_pkg::RES_TICK;
      res_temp  <= '0;
      res_flags <= '0;
      res_time  <= '0;
    end
    if (cmd.div_init) begin
      prod <= tsf_pkg::PROD_W'(item_rand) * tsf_pkg::PROD_W'(recip);
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      rem_est <= rem_diff;
      rem     <= rem_next[tsf_pkg::DIV_W-1:0];
      dcnt    <= dcnt + 1'b1;
    end
    if (cmd.calc) begin
      temp <= sat_temp(calc_sum);
    end
    if (cmd.read_empty) begin
      res_code <= tsf_pkg::RES_EMPTY;
    end
    if (cmd.push) begin
      res_code  <= tsf_pkg::RES_SAMPLE;
      res_temp  <= temp;
      res_flags <= {alert_flag, 1'b1};
      res_time  <= item_time;
    end
    if (cmd.pop) begin
      res_code  <= tsf_pkg::RES_READ;
      res_temp  <= ram_rdata[tsf_pkg::TEMP_W-1:0];
      res_flags <= ram_rdata[tsf_pkg::E_ALERT:tsf_pkg::E_NEW];
      res_time  <= ram_rdata[tsf_pkg::ENTRY_W-1:tsf_pkg::E_ALERT+1];
    end
    if (cmd.load_out) begin
      result_code    <= res_code;
      sample_temp_mc <= res_temp;
      sample_flags   <= res_flags;
      sample_time_ns <= res_time;
      data_ready     <= !st.empty;
      alert_pending  <= oldest_alert;
      update_total   <= upd_cnt;
      alert_total    <= alr_cnt;
    end
  end

endmodule

`default_nettype wire

>>> src/tsf_ctrl.sv
// controller state machine: sequences one item through the datapath
// depends on tsf_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "temp_sensor_sample_fifo_top_macros.svh"

module tsf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire tsf_pkg::status_t st,
  output tsf_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_CALC,
    S_PUSH,
    S_RD_WAIT,
    S_RD_TAKE,
    S_LK_WAIT,
    S_LK_TAKE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (st.kind)
          tsf_pkg::KIND_TICK: begin
            cmd.tick_eval = 1'b1;
            if (!st.hit) begin
              state_next = S_FINISH;
            end else if (st.mode_ramp) begin
              state_next = S_CALC;
            end else begin
              cmd.div_init = 1'b1;
              state_next   = S_DIV;
            end
          end
          tsf_pkg::KIND_READ: begin
            if (st.empty) begin
              cmd.read_empty = 1'b1;
              state_next     = S_FINISH;
            end else begin
              state_next = S_RD_WAIT;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = st.full ? S_LK_WAIT : S_FINISH;
      end
      S_RD_WAIT: state_next = S_RD_TAKE;
      S_RD_TAKE: begin
        cmd.pop    = 1'b1;
        state_next = st.more ? S_LK_WAIT : S_FINISH;
      end
      S_LK_WAIT: state_next = S_LK_TAKE;
      S_LK_TAKE: begin
        cmd.lookup = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TSF_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `TSF_ASSERT_NEXT(a_load_shows_result, clk, rst, cmd.load_out, out_valid)
  `TSF_ASSERT_IMPL(a_no_overwrite, clk, rst, out_valid && !out_ready, !cmd.load_out)

endmodule

`default_nettype wire

>>> src/temp_sensor_sample_fifo_top.sv
// top level of the simulated temperature sensor with sample ring
// depends on tsf_pkg, tsf_ctrl, tsf_datapath (and tsf_ram below it)
`timescale 1ns / 1ps
`default_nettype none

// Simulated temperature sensor. Each input beat is a millisecond tick, a read
// of the oldest sample, a status query or an idle beat; each gives one result.
// Ticks are divided by the sample period; a sampling tick makes a ramp value or
// a mean plus an offset from the random word, flags it against the alert
// threshold, stamps it and pushes it into a 64-entry ring that drops its oldest
// entry when full (at most 63 samples held). Items are taken one at a time:
// a tick without sample, a status query, an idle beat or an empty read goes
// from decide to finish; a ramp sample passes calc and push; a normal or
// noisy sample first passes div for the remainder of the random word, formed
// by a reciprocal multiply and one correcting subtract; a read passes read
// wait and take. Whenever the oldest entry changes to one already in the ring
// (a pop, or a push that drops an entry), lookup wait and take states read
// its alert flag through the single ring read port. The ring memory is not
// cleared after reset and never needs to be. A finished result waits in the
// output register while the next beat is accepted; a result still waiting
// when the next one is finished holds the block until it is taken.
// Configuration writes are always ready and are meant for idle time.
module temp_sensor_sample_fifo_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [tsf_pkg::IN_DATA_W-1:0]      s_tdata,   // stamp_ns, random_word
  input  wire logic [tsf_pkg::KIND_W-1:0]         s_tuser,   // kind
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [tsf_pkg::OUT_DATA_W-1:0]     m_tdata,   // sample_temp_mc, sample_flags,
                                                             // sample_time_ns, data_ready,
                                                             // alert_pending, update_total,
                                                             // alert_total, zero fill
  output logic      [tsf_pkg::CODE_W-1:0]         m_tuser,   // result_code
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tsf_pkg::cmd_t                     cmd;
  tsf_pkg::status_t                  st;
  logic signed [tsf_pkg::TEMP_W-1:0] sample_temp_mc;
  logic [tsf_pkg::FLAG_W-1:0]        sample_flags;
  logic [tsf_pkg::TIME_W-1:0]        sample_time_ns;
  logic                              data_ready;
  logic                              alert_pending;
  logic [tsf_pkg::CNT_W-1:0]         update_total;
  logic [tsf_pkg::CNT_W-1:0]         alert_total;

  assign cfg_ready = 1'b1;

  tsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tsf_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (s_tuser),
    .in_stamp_ns     (s_tdata[tsf_pkg::TIME_W-1:0]),
    .in_random_word  (s_tdata[tsf_pkg::TIME_W+tsf_pkg::RAND_W-1:tsf_pkg::TIME_W]),
    .cmd             (cmd),
    .st              (st),
    .result_code     (m_tuser),
    .sample_temp_mc  (sample_temp_mc),
    .sample_flags    (sample_flags),
    .sample_time_ns  (sample_time_ns),
    .data_ready      (data_ready),
    .alert_pending   (alert_pending),
    .update_total    (update_total),
    .alert_total     (alert_total)
  );

  assign m_tdata = tsf_pkg::OUT_DATA_W'({alert_total, update_total, alert_pending, data_ready,
                                         sample_time_ns, sample_flags, sample_temp_mc});

endmodule

`default_nettype wire
